@@ sv/crcfh_pkg.sv @@
`default_nettype none

package crcfh_pkg;

  // Reflected IEEE 802.3 CRC-32
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  // Bytes in the CRC header
  localparam logic [2:0] HEADER_BYTES = 3'd4;

  // Configuration register indexes
  localparam logic REG_CHECK_DIRECTION = 1'b0;
  localparam logic REG_HEADER_AT_START = 1'b1;

  // What one accepted byte produces at the end of a frame
  typedef struct packed {
    logic        build_emit;  // four CRC bytes go out
    logic        check_emit;  // one verdict goes out
    logic        ok;          // verdict of a check frame
    logic [31:0] crc;         // final CRC, already inverted
  } crcfh_result_t;

  // One byte through the reflected CRC, a bit at a time
  function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                  input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'h000000, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/crcfh_frame.sv @@
`default_nettype none

module crcfh_frame (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     last_byte,
  input  wire logic                     check_direction,
  input  wire logic                     header_at_start,
  output crcfh_pkg::crcfh_result_t      result
);
  import crcfh_pkg::*;

  logic [31:0] crc_accum;
  logic [2:0]  bytes_seen;
  logic [31:0] expected_crc;

  logic [31:0] crc_accum_next;
  logic [2:0]  bytes_seen_next;
  logic [31:0] expected_crc_next;
  logic        capture;
  logic [31:0] lane;

  // Capture header bytes in check mode while fewer than four are in
  assign capture = check_direction && (bytes_seen < HEADER_BYTES);

  // Place the byte in its little-endian lane
  always_comb begin
    unique case (bytes_seen[1:0])
      2'd0:    lane = {24'h000000, data_byte};
      2'd1:    lane = {16'h0000, data_byte, 8'h00};
      2'd2:    lane = {8'h00, data_byte, 16'h0000};
      default: lane = {data_byte, 24'h000000};
    endcase
  end

  // Advance either the header capture or the CRC
  always_comb begin
    if (capture) begin
      crc_accum_next    = crc_accum;
      bytes_seen_next   = bytes_seen + 3'd1;
      expected_crc_next = expected_crc | lane;
    end else begin
      crc_accum_next    = crc_byte_update(crc_accum, data_byte);
      bytes_seen_next   = bytes_seen;
      expected_crc_next = expected_crc;
    end
  end

  // Form the end-of-frame outcome
  always_comb begin
    result.crc        = crc_accum_next ^ CRC_ALL_ONES;
    result.ok         = header_at_start && (bytes_seen_next >= HEADER_BYTES) &&
                        (result.crc == expected_crc_next);
    result.check_emit = last_byte && check_direction;
    result.build_emit = last_byte && !check_direction && header_at_start;
  end

  // Hold frame state; drop it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= CRC_ALL_ONES;
      bytes_seen   <= 3'd0;
      expected_crc <= 32'h00000000;
    end else if (accept) begin
      if (last_byte) begin
        crc_accum    <= CRC_ALL_ONES;
        bytes_seen   <= 3'd0;
        expected_crc <= 32'h00000000;
      end else begin
        crc_accum    <= crc_accum_next;
        bytes_seen   <= bytes_seen_next;
        expected_crc <= expected_crc_next;
      end
    end
  end

  header_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= HEADER_BYTES)
    else $error("header byte count beyond four");

  no_capture_in_build: assert property (@(posedge clk) disable iff (rst)
    accept && !check_direction && !last_byte |=> $stable(expected_crc))
    else $error("expected CRC changed in build mode");

  frame_state_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> crc_accum == CRC_ALL_ONES && bytes_seen == 3'd0)
    else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

@@ sv/crc32_frame_header_gen_check.sv @@
`default_nettype none

// CRC-32 frame header builder and checker (reflected IEEE 802.3 CRC-32).
// Frame bytes enter one per transaction on data_byte/last_byte, and a byte is
// taken in every cycle unless it is a last byte held back by in_ready: the
// CRC update of one byte sits between the input port and the frame state
// registers. In build mode (check_direction = 0, header_at_start = 1) the
// last byte of a frame yields four result transactions carrying the CRC, low
// byte first, drained one per cycle while out_ready is high from a four-deep
// output shift register; in check mode (check_direction = 1) the first four
// bytes are the expected CRC and the last byte yields one verdict on check_ok.
// A last byte waits on in_ready only while the output register still holds
// results that will not have left by the next edge. Write the configuration
// registers only between frames, with no results pending.
module crc32_frame_header_gen_check (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  // byte stream in
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  // results out
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            check_ok,
  output logic            final_result
);
  import crcfh_pkg::*;

  logic          check_direction;
  logic          header_at_start;

  logic          in_fire;
  logic          out_fire;
  logic          buf_free;
  logic          load;
  crcfh_result_t result;

  // output buffer
  logic [2:0]    obuf_cnt;
  logic [2:0]    obuf_cnt_next;
  logic [31:0]   obuf_crc;
  logic          obuf_check;
  logic          obuf_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_direction <= 1'b0;
      header_at_start <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHECK_DIRECTION: check_direction <= cfg_data;
        default:             header_at_start <= cfg_data;
      endcase
    end
  end

  // Handshakes: a last byte needs room in the output buffer
  assign out_valid = (obuf_cnt != 3'd0);
  assign out_fire  = out_valid && out_ready;
  assign buf_free  = (obuf_cnt == 3'd0) || ((obuf_cnt == 3'd1) && out_ready);
  assign in_ready  = !last_byte || buf_free;
  assign in_fire   = in_valid && in_ready;

  crcfh_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .accept          (in_fire),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .check_direction (check_direction),
    .header_at_start (header_at_start),
    .result          (result)
  );

  assign load = in_fire && (result.check_emit || result.build_emit);

  // Result count: load on a frame end, count down on each transaction out
  always_comb begin
    priority if (load) begin
      obuf_cnt_next = result.build_emit ? HEADER_BYTES : 3'd1;
    end else if (out_fire) begin
      obuf_cnt_next = obuf_cnt - 3'd1;
    end else begin
      obuf_cnt_next = obuf_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_cnt <= 3'd0;
    end else begin
      obuf_cnt <= obuf_cnt_next;
    end
  end

  // Result payload: shift out one CRC byte per transaction
  always_ff @(posedge clk) begin
    if (load) begin
      obuf_crc   <= result.crc;
      obuf_check <= result.check_emit;
      obuf_ok    <= result.ok;
    end else if (out_fire) begin
      obuf_crc   <= {8'h00, obuf_crc[31:8]};
    end
  end

  assign out_byte     = obuf_check ? 8'h00 : obuf_crc[7:0];
  assign check_ok     = obuf_check && obuf_ok;
  assign final_result = (obuf_cnt == 3'd1);

  buffer_count_bound: assert property (@(posedge clk) disable iff (rst)
    obuf_cnt <= HEADER_BYTES)
    else $error("output buffer count beyond four");

  verdict_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte && check_direction |=> out_valid && final_result)
    else $error("check frame end gave no verdict");

  build_loads_four: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte && !check_direction && header_at_start |=>
    obuf_cnt == HEADER_BYTES)
    else $error("build frame end did not load four CRC bytes");

  check_has_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_ok |-> out_byte == 8'h00 && final_result)
    else $error("verdict carries a data byte or is not final");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfh_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_LIMIT   = 20000;

  // One result transaction as it leaves the block
  typedef struct packed {
    logic [7:0] crc_byte;
    logic       verdict;
    logic       frame_end;
  } result_t;

  // Directed stimulus: a byte transaction or a register write
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic        cfg_idx;
    logic        cfg_val;
    logic        typed;     // expected results written out in the row
    logic [2:0]  fx_count;  // 0, 1 or 4 results
    logic [31:0] fx_crc;
    logic        fx_ok;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       check_ok;
  logic       final_result;

  // Shadow of the block's registers and frame state
  logic        mode_check = 1'b0;
  logic        hdr_first = 1'b1;
  logic [31:0] run_crc = CRC_ALL_ONES;
  logic [2:0]  hdr_count = 3'd0;
  logic [31:0] hdr_crc = 32'h0;

  result_t   results_q[$];
  stim_row_t directed_rows[$];
  int        err_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        hold_request = 1'b0;

  crc32_frame_header_gen_check uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .check_ok     (check_ok),
    .final_result (final_result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bound the run
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Advance the reflected CRC by one byte, feedback taken per input bit
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ b[k]) ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  // Track one accepted byte; queue the results it causes when asked to
  function automatic void predict_byte(logic [7:0] d, logic l, bit push);
    logic [31:0] fin;
    logic        ok;
    if (mode_check && hdr_count < HEADER_BYTES) begin
      hdr_crc = hdr_crc | ({24'h0, d} << (8 * hdr_count));
      hdr_count = hdr_count + 3'd1;
    end else begin
      run_crc = crc_step(run_crc, d);
    end
    if (l) begin
      fin = run_crc ^ CRC_ALL_ONES;
      if (mode_check) begin
        ok = hdr_first && hdr_count == HEADER_BYTES && fin == hdr_crc;
        if (push) results_q.push_back({8'h00, ok, 1'b1});
      end else if (hdr_first && push) begin
        for (int k = 0; k < 4; k++) results_q.push_back({fin[8*k +: 8], 1'b0, k == 3});
      end
      run_crc = CRC_ALL_ONES;
      hdr_count = 3'd0;
      hdr_crc = 32'h0;
    end
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] d, logic l);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(logic [7:0] d, logic l, logic [2:0] cnt,
                                          logic [31:0] crc, logic ok);
    stim_row_t r;
    r = byte_row(d, l);
    r.typed = 1'b1;
    r.fx_count = cnt;
    r.fx_crc = crc;
    r.fx_ok = ok;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Bias toward all-zero and all-one bytes
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Offer one byte and hold it until the transaction completes
  task automatic offer_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write a register once the output has drained and the block has settled
  task automatic write_reg(input logic idx, input logic val);
    in_valid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_CHECK_DIRECTION) mode_check = val;
    else hdr_first = val;
  endtask

  // Send one frame shaped for the current mode; return its byte count
  task automatic send_random_frame(output int sent);
    logic [7:0]  bytes[$];
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [31:0] body_crc;
    int          pick;
    int          len;
    int          pos;
    pick = $urandom_range(99);
    if (mode_check && pick < 15) begin
      // short frame: header never completes
      len = $urandom_range(1, 3);
      repeat (len) bytes.push_back(rand_byte());
    end else if (mode_check) begin
      len = $urandom_range(0, 6);
      body_crc = CRC_ALL_ONES;
      repeat (len) begin
        b = rand_byte();
        body.push_back(b);
        body_crc = crc_step(body_crc, b);
      end
      body_crc = body_crc ^ CRC_ALL_ONES;
      for (int k = 0; k < 4; k++) bytes.push_back(body_crc[8*k +: 8]);
      foreach (body[i]) bytes.push_back(body[i]);
      // corrupt one bit in some frames
      if (pick < 35) begin
        pos = $urandom_range(0, bytes.size() - 1);
        bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else begin
      len = (pick < 10) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      repeat (len) bytes.push_back(rand_byte());
    end
    foreach (bytes[i]) begin
      offer_byte(bytes[i], i == bytes.size() - 1);
      predict_byte(bytes[i], i == bytes.size() - 1, 1'b1);
    end
    sent = bytes.size();
  endtask

  task automatic run_segment(input logic chk, input logic at_start, input int n_items);
    int done;
    int sent;
    done = 0;
    write_reg(REG_CHECK_DIRECTION, chk);
    write_reg(REG_HEADER_AT_START, at_start);
    while (done < n_items) begin
      send_random_frame(sent);
      done += sent;
    end
  endtask

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_q.size() == 0) begin
        $error("unexpected result: out_byte %0h check_ok %0b final_result %0b",
               out_byte, check_ok, final_result);
        err_count++;
      end else begin
        want = results_q.pop_front();
        if (out_byte !== want.crc_byte) begin
          $error("out_byte: expected %0h, got %0h", want.crc_byte, out_byte);
          err_count++;
        end
        if (check_ok !== want.verdict) begin
          $error("check_ok: expected %0b, got %0b", want.verdict, check_ok);
          err_count++;
        end
        if (final_result !== want.frame_end) begin
          $error("final_result: expected %0b, got %0b", want.frame_end, final_result);
          err_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int        waited;

    // build mode after reset: single-byte frames with well-known CRCs, then a two-byte frame
    directed_rows.push_back(fixed_row(8'h00, 1'b1, 3'd4, 32'hD202EF8D, 1'b0));
    directed_rows.push_back(fixed_row(8'hFF, 1'b1, 3'd4, 32'hFF000000, 1'b0));
    directed_rows.push_back(byte_row(8'hA5, 1'b0));
    directed_rows.push_back(byte_row(8'h5A, 1'b1));
    // check mode: zero header over an empty body passes
    directed_rows.push_back(cfg_row(REG_CHECK_DIRECTION, 1'b1));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(fixed_row(8'h00, 1'b1, 3'd1, 32'h0, 1'b1));
    // short frame fails
    directed_rows.push_back(byte_row(8'h12, 1'b0));
    directed_rows.push_back(fixed_row(8'h34, 1'b1, 3'd1, 32'h0, 1'b0));
    // header elsewhere: the same good frame now fails
    directed_rows.push_back(cfg_row(REG_HEADER_AT_START, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(fixed_row(8'h00, 1'b1, 3'd1, 32'h0, 1'b0));
    // header elsewhere in build mode: nothing comes out
    directed_rows.push_back(cfg_row(REG_CHECK_DIRECTION, 1'b0));
    directed_rows.push_back(fixed_row(8'h7F, 1'b1, 3'd0, 32'h0, 1'b0));
    directed_rows.push_back(cfg_row(REG_HEADER_AT_START, 1'b1));
    // mode flips inside a frame: two bytes captured, the last one hashed
    directed_rows.push_back(cfg_row(REG_CHECK_DIRECTION, 1'b1));
    directed_rows.push_back(byte_row(8'h11, 1'b0));
    directed_rows.push_back(byte_row(8'h22, 1'b0));
    directed_rows.push_back(cfg_row(REG_CHECK_DIRECTION, 1'b0));
    directed_rows.push_back(byte_row(8'h33, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 73;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        offer_byte(row.data, row.last);
        predict_byte(row.data, row.last, !row.typed);
        if (row.typed && row.fx_count == 3'd1) begin
          results_q.push_back({8'h00, row.fx_ok, 1'b1});
        end else if (row.typed && row.fx_count == 3'd4) begin
          for (int k = 0; k < 4; k++) results_q.push_back({row.fx_crc[8*k +: 8], 1'b0, k == 3});
        end
      end
    end

    // Random frames under each idling mix and register setting
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 73 : 0;
      rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 14 : 0;
      if (ph == 2) hold_request = 1'b1;
      run_segment(1'b0, 1'b1, 50);
      run_segment(1'b1, 1'b1, 50);
      run_segment(1'b1, 1'b0, 12);
      run_segment(1'b0, 1'b0, 12);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    waited = 0;
    while (results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_q.size() != 0) begin
      $error("%0d expected results never arrived", results_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
